// ===== hdl/blcs_pkg.sv =====
// ----------------------------------------------------------------------------
// blcs_pkg - shared definitions for the linear classifier scorer
// Field widths, word layouts, opcodes, confusion classes and the
// saturating accumulator helper.
// ----------------------------------------------------------------------------
`default_nettype none

package blcs_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_PIXELS  = 1024;
    localparam int DEF_WEIGHT_BITS = 16;

    // Fixed field widths.
    localparam int OPC_W  = 2;
    localparam int IDX_W  = 10;
    localparam int WVAL_W = 16;
    localparam int PIX_W  = 8;
    localparam int LBL_W  = 8;
    localparam int BIAS_W = 32;
    localparam int CNT_W  = 32;
    localparam int ACC_W  = 40;
    localparam int SUM_W  = ACC_W + 2;
    localparam int N_CLASS = 4;

    // Input word layout, lowest bit first.
    localparam int IN_IDX_LSB    = 0;
    localparam int IN_WVAL_LSB   = IN_IDX_LSB + IDX_W;
    localparam int IN_PIX_LSB    = IN_WVAL_LSB + WVAL_W;
    localparam int IN_LBL_LSB    = IN_PIX_LSB + PIX_W;
    localparam int IN_FIELDS_W   = IN_LBL_LSB + LBL_W;
    localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;

    // Output word layout: predicted_zero, correct, then four counters.
    localparam int OUT_FIELDS_W  = 2 + N_CLASS * CNT_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OPC_W-1:0] {
        OP_WRITE_WEIGHT = 2'd0,
        OP_PIXEL        = 2'd1,
        OP_CLEAR        = 2'd2
    } t_opcode;

    // Confusion counter slots.
    localparam logic [1:0] CLS_OTHER_CORRECT = 2'd0;
    localparam logic [1:0] CLS_OTHER_WRONG   = 2'd1;
    localparam logic [1:0] CLS_ZERO_CORRECT  = 2'd2;
    localparam logic [1:0] CLS_ZERO_WRONG    = 2'd3;

    // Token that walks down the pipeline with each pixel or clear word.
    typedef struct packed {
        logic valid;
        logic is_clear;
        logic last;
        logic label_zero;
        logic use_weight;
    } t_tok;

    // Clamp a widened sum into the signed accumulator range.
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-ACC_W:0] top;
        top = s[SUM_W-1:ACC_W-1];
        if (top == '0 || top == '1) begin
            return s[ACC_W-1:0];
        end else if (s[SUM_W-1]) begin
            return {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            return {1'b0, {(ACC_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/binary_linear_classifier_scorer_unit.sv =====
// ----------------------------------------------------------------------------
// binary_linear_classifier_scorer_unit - logistic-regression image scorer
// Weight store, pixel multiply-accumulate, bias, decision and confusion
// counters behind a pair of streaming ports.
// ----------------------------------------------------------------------------
// The block takes one input word per clock cycle while it is ready, and emits
// one result word for every pixel word marked with tlast. The opcode in tuser
// selects a weight write, a pixel or a clear of the four confusion counters.
// Weight writes land in the store at once; pixels are scored in stream order
// against the weight at their running position. On its way out a result
// moves through, in order: the weight read at the edge that takes its last
// pixel, the product, the accumulator, the bias-added decision and the
// counter update into the output register. The input stays ready while
// a result waits at the output; it only stalls once the output is held and
// the stages behind it are full. The user must write the bias through the
// configuration port while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_linear_classifier_scorer_unit #(
    parameter int MAX_PIXELS  = blcs_pkg::DEF_MAX_PIXELS,
    parameter int WEIGHT_BITS = blcs_pkg::DEF_WEIGHT_BITS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // Bias register write.
    input  wire logic                                 i_cfg_we,
    input  wire logic [blcs_pkg::BIAS_W-1:0]          i_cfg_wdata,
    // Input stream.
    input  wire logic                                 i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    // tdata fields from bit 0: weight_index, weight_value, pixel, label, zero pad.
    input  wire logic [blcs_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // tuser field: opcode.
    input  wire logic [blcs_pkg::OPC_W-1:0]           i_s_axis_tuser,
    // tlast: last_pixel.
    input  wire logic                                 i_s_axis_tlast,
    // Result stream.
    output logic                                      o_m_axis_tvalid,
    input  wire logic                                 i_m_axis_tready,
    // tdata fields from bit 0: predicted_zero, correct, count_other_correct,
    // count_other_wrong, count_zero_correct, count_zero_wrong, zero pad.
    output logic [blcs_pkg::OUT_TDATA_W-1:0]          o_m_axis_tdata
);

    // The position counter must be able to hold MAX_PIXELS itself.
    localparam int AW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int POS_W = $clog2(MAX_PIXELS + 1);
    localparam int CW    = (POS_W > blcs_pkg::IDX_W) ? POS_W : blcs_pkg::IDX_W;

    logic                                   accept;
    blcs_pkg::t_opcode                      in_opc;
    logic                                   is_wr, is_pix, is_clr;
    logic [blcs_pkg::IDX_W-1:0]             in_idx;
    logic [CW-1:0]                          idx_ext;
    logic                                   wr_ok;
    logic signed [WEIGHT_BITS-1:0]          wr_weight;
    logic [blcs_pkg::PIX_W-1:0]             in_pixel;
    logic [blcs_pkg::LBL_W-1:0]             in_label;
    logic [POS_W-1:0]                       r_pos;
    logic                                   pos_in_range;
    logic [AW-1:0]                          rd_addr;
    logic [WEIGHT_BITS-1:0]                 rd_weight;
    blcs_pkg::t_tok                         r_s1, n_s1;
    logic [blcs_pkg::PIX_W-1:0]             r_pixel;
    logic signed [blcs_pkg::BIAS_W-1:0]     r_bias;
    logic                                   mac_ready, tally_ready;
    blcs_pkg::t_tok                         mac_tok;
    logic signed [blcs_pkg::ACC_W-1:0]      mac_sum;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign in_opc = blcs_pkg::t_opcode'(i_s_axis_tuser);

    always_comb begin
        is_wr  = 1'b0;
        is_pix = 1'b0;
        is_clr = 1'b0;
        unique case (in_opc)
            blcs_pkg::OP_WRITE_WEIGHT: begin
                is_wr = 1'b1;
            end
            blcs_pkg::OP_PIXEL: begin
                is_pix = 1'b1;
            end
            blcs_pkg::OP_CLEAR: begin
                is_clr = 1'b1;
            end
            default: begin
                // Unused opcode: the word is dropped.
            end
        endcase
    end

    assign in_idx   = i_s_axis_tdata[blcs_pkg::IN_IDX_LSB +: blcs_pkg::IDX_W];
    assign in_pixel = i_s_axis_tdata[blcs_pkg::IN_PIX_LSB +: blcs_pkg::PIX_W];
    assign in_label = i_s_axis_tdata[blcs_pkg::IN_LBL_LSB +: blcs_pkg::LBL_W];

    // Writes beyond the store are ignored. A narrow store keeps the low
    // bits of the weight and reads them back sign-extended; a wide one
    // sign-extends on the way in.
    assign idx_ext   = CW'(in_idx);
    assign wr_ok     = idx_ext < CW'(MAX_PIXELS);
    assign wr_weight = WEIGHT_BITS'($signed(
                           i_s_axis_tdata[blcs_pkg::IN_WVAL_LSB +: blcs_pkg::WVAL_W]));

    // Once the image runs past the store, extra pixels add nothing.
    assign pos_in_range = r_pos < POS_W'(MAX_PIXELS);
    assign rd_addr      = pos_in_range ? r_pos[AW-1:0] : '0;

    blcs_wstore #(
        .DEPTH   (MAX_PIXELS),
        .DW      (WEIGHT_BITS)
    ) u_wstore (
        .i_clk   (i_clk),
        .i_we    (accept && is_wr && wr_ok),
        .i_waddr (idx_ext[AW-1:0]),
        .i_wdata (wr_weight),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (rd_weight)
    );

    // Input stage: the token is captured together with the weight read.
    assign o_s_axis_tready = !r_s1.valid || mac_ready;

    always_comb begin
        n_s1.valid      = accept && (is_pix || is_clr);
        n_s1.is_clear   = is_clr;
        n_s1.last       = is_pix && i_s_axis_tlast;
        n_s1.label_zero = (in_label == '0);
        n_s1.use_weight = is_pix && pos_in_range;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= '0;
            r_pos  <= '0;
            r_bias <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_s1 <= n_s1;
            end
            if (accept && is_pix) begin
                if (i_s_axis_tlast) begin
                    r_pos <= '0;
                end else if (pos_in_range) begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            if (i_cfg_we) begin
                r_bias <= $signed(i_cfg_wdata);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pixel <= in_pixel;
        end
    end

    blcs_mac #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tok    (r_s1),
        .i_pixel  (r_pixel),
        .i_weight ($signed(rd_weight)),
        .o_ready  (mac_ready),
        .o_tok    (mac_tok),
        .o_sum    (mac_sum),
        .i_ready  (tally_ready)
    );

    blcs_tally u_tally (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bias   (r_bias),
        .i_tok    (mac_tok),
        .i_sum    (mac_sum),
        .o_ready  (tally_ready),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== hdl/blcs_wstore.sv =====
// ----------------------------------------------------------------------------
// blcs_wstore - weight store
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module blcs_wstore #(
    parameter int DEPTH = blcs_pkg::DEF_MAX_PIXELS,
    parameter int DW    = blcs_pkg::DEF_WEIGHT_BITS,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/blcs_mac.sv =====
// ----------------------------------------------------------------------------
// blcs_mac - multiply and accumulate stages
// Registers the pixel-weight product, then folds it into the saturating
// accumulator. The sum of a finished image is handed on with its token.
// ----------------------------------------------------------------------------
`default_nettype none

module blcs_mac #(
    parameter int WEIGHT_BITS = blcs_pkg::DEF_WEIGHT_BITS,
    localparam int PW = WEIGHT_BITS + blcs_pkg::PIX_W + 1
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire blcs_pkg::t_tok                      i_tok,
    input  wire logic [blcs_pkg::PIX_W-1:0]          i_pixel,
    input  wire logic signed [WEIGHT_BITS-1:0]       i_weight,
    output logic                                     o_ready,
    output blcs_pkg::t_tok                           o_tok,
    output logic signed [blcs_pkg::ACC_W-1:0]        o_sum,
    input  wire logic                                i_ready
);

    blcs_pkg::t_tok                        r_tok2, r_tok3, n_tok3;
    logic signed [PW-1:0]                  r_prod, n_prod;
    logic signed [blcs_pkg::ACC_W-1:0]     r_acc, r_sum, acc_plus;
    logic                                  r2_fwd, r3_free, r2_move;

    // The pixel is unsigned, so it gets a zero sign bit before the multiply.
    always_comb begin
        n_prod = $signed({1'b0, i_pixel}) * i_weight;
        if (!i_tok.use_weight) begin
            n_prod = '0;
        end
    end

    assign acc_plus = blcs_pkg::sat_acc(blcs_pkg::SUM_W'(r_acc) + blcs_pkg::SUM_W'(r_prod));

    // Ordinary pixels only touch the accumulator; last pixels and clears
    // need the hand-off register.
    assign r2_fwd  = r_tok2.last || r_tok2.is_clear;
    assign r3_free = !r_tok3.valid || i_ready;
    assign r2_move = r_tok2.valid && (!r2_fwd || r3_free);
    assign o_ready = !r_tok2.valid || r2_move;

    always_comb begin
        n_tok3       = r_tok2;
        n_tok3.valid = r2_move && r2_fwd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok2 <= '0;
            r_tok3 <= '0;
            r_acc  <= '0;
        end else begin
            if (o_ready) begin
                r_tok2 <= i_tok;
            end
            if (r3_free) begin
                r_tok3 <= n_tok3;
            end
            if (r2_move && !r_tok2.is_clear) begin
                r_acc <= r_tok2.last ? '0 : acc_plus;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_prod <= n_prod;
        end
        if (r2_move && r_tok2.last && !r_tok2.is_clear) begin
            r_sum <= acc_plus;
        end
    end

    assign o_tok = r_tok3;
    assign o_sum = r_sum;

endmodule

`default_nettype wire

// ===== hdl/blcs_tally.sv =====
// ----------------------------------------------------------------------------
// blcs_tally - decision, confusion counters and result register
// Adds the bias, decides the class, bumps one saturating counter (or clears
// all four on a clear word) and holds the outgoing result word.
// ----------------------------------------------------------------------------
`default_nettype none

module blcs_tally (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic signed [blcs_pkg::BIAS_W-1:0]  i_bias,
    input  wire blcs_pkg::t_tok                      i_tok,
    input  wire logic signed [blcs_pkg::ACC_W-1:0]   i_sum,
    output logic                                     o_ready,
    output logic                                     o_tvalid,
    input  wire logic                                i_tready,
    output logic [blcs_pkg::OUT_TDATA_W-1:0]         o_tdata
);

    blcs_pkg::t_tok                       r_tok4;
    logic                                 r_pred, n_pred;
    logic signed [blcs_pkg::ACC_W-1:0]    score;
    logic                                 out_free, r4_move, correct;
    logic [1:0]                           cls;
    logic [blcs_pkg::CNT_W-1:0]           r_cnt [blcs_pkg::N_CLASS];
    logic [blcs_pkg::CNT_W-1:0]           n_cnt [blcs_pkg::N_CLASS];
    logic                                 r_out_valid;
    logic [blcs_pkg::OUT_TDATA_W-1:0]     r_tdata;

    assign score  = blcs_pkg::sat_acc(blcs_pkg::SUM_W'(i_sum) + blcs_pkg::SUM_W'(i_bias));
    // A score of exactly zero is not above one half after the sigmoid.
    assign n_pred = !score[blcs_pkg::ACC_W-1] && (score != '0);

    assign out_free = !r_out_valid || i_tready;
    assign r4_move  = r_tok4.valid && (r_tok4.is_clear || out_free);
    assign o_ready  = !r_tok4.valid || r4_move;

    assign correct = (r_pred == r_tok4.label_zero);

    always_comb begin
        if (r_tok4.label_zero) begin
            cls = r_pred ? blcs_pkg::CLS_ZERO_CORRECT : blcs_pkg::CLS_ZERO_WRONG;
        end else begin
            cls = r_pred ? blcs_pkg::CLS_OTHER_WRONG : blcs_pkg::CLS_OTHER_CORRECT;
        end
    end

    always_comb begin
        for (int k = 0; k < blcs_pkg::N_CLASS; k++) begin
            n_cnt[k] = r_cnt[k];
            if (r_tok4.is_clear) begin
                n_cnt[k] = '0;
            end else if (2'(k) == cls && r_cnt[k] != '1) begin
                n_cnt[k] = r_cnt[k] + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok4      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < blcs_pkg::N_CLASS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            if (o_ready) begin
                r_tok4 <= i_tok;
            end
            if (out_free) begin
                r_out_valid <= r4_move && !r_tok4.is_clear;
            end
            if (r4_move) begin
                for (int k = 0; k < blcs_pkg::N_CLASS; k++) begin
                    r_cnt[k] <= n_cnt[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_pred <= n_pred;
        end
        if (r4_move && !r_tok4.is_clear) begin
            r_tdata <= blcs_pkg::OUT_TDATA_W'({n_cnt[3], n_cnt[2], n_cnt[1], n_cnt[0],
                                               correct, r_pred});
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_tdata;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the linear classifier scorer unit
// Loads the weight store, streams images of pixel words with random content
// and random idling on both ports, predicts every result word in step with
// each accepted input word and compares them field by field as they leave.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int STORE_DEPTH = blcs_pkg::DEF_MAX_PIXELS;
    localparam int IN_PAD_W    = blcs_pkg::IN_TDATA_W - blcs_pkg::IN_FIELDS_W;
    localparam int OUT_PAD_W   = blcs_pkg::OUT_TDATA_W - blcs_pkg::OUT_FIELDS_W;
    // Cycles to let pass once all results are in: the block's own latency plus margin.
    localparam int IDLE_TAIL   = 12;
    localparam int DRAIN_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_WORDS   = 60;
    // The opcode the block must ignore; it has no member in the package enum.
    localparam logic [blcs_pkg::OPC_W-1:0] OPC_RESERVED = 2'd3;
    localparam longint ACC_TOP = (longint'(1) << (blcs_pkg::ACC_W - 1)) - 1;
    localparam longint ACC_BOT = -ACC_TOP - 1;

    // Input word fields, packed exactly as the tdata port carries them.
    typedef struct packed {
        logic [IN_PAD_W-1:0]              pad;
        logic [blcs_pkg::LBL_W-1:0]       label;
        logic [blcs_pkg::PIX_W-1:0]       pixel;
        logic [blcs_pkg::WVAL_W-1:0]      weight_value;
        logic [blcs_pkg::IDX_W-1:0]       weight_index;
    } t_in_fields;

    typedef struct {
        logic [blcs_pkg::OPC_W-1:0] opc;
        logic                       last;
        t_in_fields                 f;
    } t_in_word;

    // Result word, packed exactly as the result tdata port carries it.
    typedef struct packed {
        logic [OUT_PAD_W-1:0]             pad;
        logic [blcs_pkg::CNT_W-1:0]       zero_wrong;
        logic [blcs_pkg::CNT_W-1:0]       zero_correct;
        logic [blcs_pkg::CNT_W-1:0]       other_wrong;
        logic [blcs_pkg::CNT_W-1:0]       other_correct;
        logic                             correct;
        logic                             predicted_zero;
    } t_result_word;

    // Block ports, every input at a known value from time zero.
    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [blcs_pkg::BIAS_W-1:0]      cfg_wdata = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [blcs_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic [blcs_pkg::OPC_W-1:0]       s_tuser = '0;
    logic                             s_tlast = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [blcs_pkg::OUT_TDATA_W-1:0] m_tdata;

    binary_linear_classifier_scorer_unit #(
        .MAX_PIXELS (STORE_DEPTH),
        .WEIGHT_BITS(blcs_pkg::DEF_WEIGHT_BITS)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .i_s_axis_tlast (s_tlast),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // The bench's own copy of the scorer state. It advances once per accepted
    // input word, in acceptance order, so it sees writes, clears and pixels
    // in the same order as the block does.
    logic signed [blcs_pkg::WVAL_W-1:0] weight_copy [STORE_DEPTH];
    logic signed [blcs_pkg::ACC_W-1:0]  acc_copy = '0;
    int                                 pixel_pos = 0;
    logic [blcs_pkg::CNT_W-1:0]         tally [blcs_pkg::N_CLASS] = '{default: '0};
    logic signed [blcs_pkg::BIAS_W-1:0] bias_copy = '0;

    t_in_word     pending_words [$];
    t_result_word expected_scores [$];
    int           mismatches = 0;
    int           results_seen = 0;

    function automatic logic signed [blcs_pkg::ACC_W-1:0] clamp_acc(input longint total);
        if (total > ACC_TOP) begin
            return blcs_pkg::ACC_W'(ACC_TOP);
        end else if (total < ACC_BOT) begin
            return blcs_pkg::ACC_W'(ACC_BOT);
        end
        return blcs_pkg::ACC_W'(total);
    endfunction

    // Works out what one accepted word does to the scorer and, on a last
    // pixel, queues the result word that the block has to send for it.
    task automatic predict_scores(input t_in_word w);
        longint          total;
        logic            pred;
        logic            truth_zero;
        logic [1:0]      slot;
        t_result_word    want;
        case (w.opc)
            blcs_pkg::OP_WRITE_WEIGHT: begin
                if (int'(w.f.weight_index) < STORE_DEPTH) begin
                    weight_copy[w.f.weight_index] = w.f.weight_value;
                end
            end
            blcs_pkg::OP_CLEAR: begin
                // A clear leaves any image in progress alone.
                for (int k = 0; k < blcs_pkg::N_CLASS; k++) begin
                    tally[k] = '0;
                end
            end
            blcs_pkg::OP_PIXEL: begin
                // Past the end of the store, pixels add nothing and the
                // position stays put, but a last pixel still ends the image.
                if (pixel_pos < STORE_DEPTH) begin
                    total = longint'(acc_copy)
                          + longint'(w.f.pixel) * longint'(weight_copy[pixel_pos]);
                    acc_copy = clamp_acc(total);
                    pixel_pos++;
                end
                if (w.last) begin
                    acc_copy = clamp_acc(longint'(acc_copy) + longint'(bias_copy));
                    // A score of exactly zero sits at one half after the
                    // sigmoid, which is not above it, so it predicts non-zero.
                    pred = (acc_copy > 0);
                    truth_zero = (w.f.label == '0);
                    if (truth_zero) begin
                        slot = pred ? blcs_pkg::CLS_ZERO_CORRECT : blcs_pkg::CLS_ZERO_WRONG;
                    end else begin
                        slot = pred ? blcs_pkg::CLS_OTHER_WRONG
                                    : blcs_pkg::CLS_OTHER_CORRECT;
                    end
                    if (tally[slot] != '1) begin
                        tally[slot] = tally[slot] + 1'b1;
                    end
                    want.pad            = '0;
                    want.predicted_zero = pred;
                    want.correct        = (pred == truth_zero);
                    want.other_correct  = tally[blcs_pkg::CLS_OTHER_CORRECT];
                    want.other_wrong    = tally[blcs_pkg::CLS_OTHER_WRONG];
                    want.zero_correct   = tally[blcs_pkg::CLS_ZERO_CORRECT];
                    want.zero_wrong     = tally[blcs_pkg::CLS_ZERO_WRONG];
                    expected_scores.insert(expected_scores.size(), want);
                    acc_copy = '0;
                    pixel_pos = 0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic note_field(input string name, input logic [blcs_pkg::CNT_W-1:0] want,
                              input logic [blcs_pkg::CNT_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("score check: result %0d field %s expected %0h got %0h",
                         results_seen, name, want, got);
            end
        end
    endtask

    task automatic check_result(input t_result_word got);
        t_result_word want;
        results_seen++;
        if (expected_scores.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("score check: result %0d arrived with nothing pending, data %0h",
                         results_seen, got);
            end
            return;
        end
        want = expected_scores.pop_front();
        note_field("predicted_zero", blcs_pkg::CNT_W'(want.predicted_zero),
                   blcs_pkg::CNT_W'(got.predicted_zero));
        note_field("correct", blcs_pkg::CNT_W'(want.correct),
                   blcs_pkg::CNT_W'(got.correct));
        note_field("count_other_correct", want.other_correct, got.other_correct);
        note_field("count_other_wrong", want.other_wrong, got.other_wrong);
        note_field("count_zero_correct", want.zero_correct, got.zero_correct);
        note_field("count_zero_wrong", want.zero_wrong, got.zero_wrong);
    endtask

    // Sender. Each word waits a drawn number of idle cycles before it is
    // offered; now and then the sender switches into a calm stretch with no
    // gaps at all. tvalid stays up across back-to-back words, so it gets
    // exactly one nonblocking assignment per edge.
    t_in_word tx_cur;
    logic     tx_offer = 1'b0;
    logic     tx_calm = 1'b0;
    int       tx_gap = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            tx_offer = 1'b0;
            tx_gap = 0;
        end else begin
            if (tx_offer && s_tready) begin
                predict_scores(tx_cur);
                tx_offer = 1'b0;
                if ($urandom_range(0, 63) == 0) begin
                    tx_calm = !tx_calm;
                end
                tx_gap = tx_calm ? 0 : $urandom_range(0, 8);
            end
            if (!tx_offer) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_words.size() > 0) begin
                    tx_cur = pending_words.pop_front();
                    tx_offer = 1'b1;
                    s_tdata <= tx_cur.f;
                    s_tuser <= tx_cur.opc;
                    s_tlast <= tx_cur.last;
                end
            end
            s_tvalid <= tx_offer;
        end
    end

    // Receiver. After each result word it stalls for a drawn number of
    // cycles, with calm stretches of its own, and it also honors the long
    // hold-off below.
    logic rx_hold = 1'b0;
    logic rx_calm = 1'b0;
    int   rx_gap = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_tready && m_tvalid) begin
                check_result(m_tdata);
                if ($urandom_range(0, 63) == 0) begin
                    rx_calm = !rx_calm;
                end
                rx_gap = rx_calm ? 0 : $urandom_range(0, 8);
            end
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Long hold-off: the receiver refuses results for a long stretch while
    // the sender keeps going, so the pipeline fills and tready must drop.
    logic hold_go = 1'b0;

    initial begin
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic queue_word(input logic [blcs_pkg::OPC_W-1:0] opc, input logic last,
                              input logic [blcs_pkg::IDX_W-1:0] idx,
                              input logic [blcs_pkg::WVAL_W-1:0] wval,
                              input logic [blcs_pkg::PIX_W-1:0] pix,
                              input logic [blcs_pkg::LBL_W-1:0] lbl);
        t_in_word w;
        w.opc            = opc;
        w.last           = last;
        w.f.pad          = '0;
        w.f.label        = lbl;
        w.f.pixel        = pix;
        w.f.weight_value = wval;
        w.f.weight_index = idx;
        pending_words.insert(pending_words.size(), w);
    endtask

    // The fields a word does not use still carry random bits.
    task automatic queue_write(input int idx, input logic [blcs_pkg::WVAL_W-1:0] wval);
        queue_word(blcs_pkg::OP_WRITE_WEIGHT, 1'($urandom_range(0, 1)),
                   blcs_pkg::IDX_W'(idx), wval,
                   blcs_pkg::PIX_W'($urandom), blcs_pkg::LBL_W'($urandom));
    endtask

    task automatic queue_pixel(input int pix, input logic last, input int lbl);
        queue_word(blcs_pkg::OP_PIXEL, last, blcs_pkg::IDX_W'($urandom),
                   blcs_pkg::WVAL_W'($urandom),
                   blcs_pkg::PIX_W'(pix), blcs_pkg::LBL_W'(lbl));
    endtask

    task automatic queue_other(input logic [blcs_pkg::OPC_W-1:0] opc);
        queue_word(opc, 1'($urandom_range(0, 1)), blcs_pkg::IDX_W'($urandom),
                   blcs_pkg::WVAL_W'($urandom),
                   blcs_pkg::PIX_W'($urandom), blcs_pkg::LBL_W'($urandom));
    endtask

    function automatic int label_draw();
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 255);
    endfunction

    // Bias mostly on the scale of a few pixel products, so that decisions
    // go both ways, and sometimes anywhere in the full range.
    function automatic logic [blcs_pkg::BIAS_W-1:0] bias_draw();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom;
        end
        return blcs_pkg::BIAS_W'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
    endfunction

    // Bias writes go in only while the block is idle, so the copy can follow
    // at once.
    task automatic write_bias(input logic [blcs_pkg::BIAS_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        bias_copy = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until the sender is empty and every predicted result is in, then
    // gives the block time to finish words that produce no result.
    task automatic wait_idle();
        int spins;
        spins = 0;
        while (pending_words.size() > 0 || tx_offer) begin
            @(posedge clk);
        end
        while (expected_scores.size() > 0 && spins < DRAIN_LIMIT) begin
            @(posedge clk);
            spins++;
        end
        repeat (IDLE_TAIL) @(posedge clk);
    endtask

    // A phase of random traffic. Most of it is whole images of random length
    // and content; weight writes and clears fall between images and now and then
    // inside one; ignored words fall only between. No phase ends inside an image.
    task automatic queue_random_phase(input int n_words);
        int made;
        int len;
        int pick;
        made = 0;
        while (made < n_words) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                queue_write($urandom_range(0, STORE_DEPTH - 1),
                            blcs_pkg::WVAL_W'($urandom));
                made++;
            end else if (pick < 14) begin
                queue_other(blcs_pkg::OP_CLEAR);
                made++;
            end else if (pick < 16) begin
                queue_other(OPC_RESERVED);
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
                                                  : $urandom_range(1, 12);
                for (int k = 0; k < len; k++) begin
                    pick = $urandom_range(0, 39);
                    if (pick == 0) begin
                        queue_write($urandom_range(0, STORE_DEPTH - 1),
                                    blcs_pkg::WVAL_W'($urandom));
                        made++;
                    end else if (pick == 1) begin
                        queue_other(blcs_pkg::OP_CLEAR);
                        made++;
                    end
                    queue_pixel($urandom_range(0, 255), k == len - 1, label_draw());
                    made++;
                end
            end
        end
    endtask

    // Stimulus and end of run.
    initial begin
        wait (rst_n);
        repeat (2) @(posedge clk);
        write_bias(bias_draw());

        // Fill the whole weight store before any pixel can read it; the
        // first and last entries take the two weight extremes.
        for (int i = 0; i < STORE_DEPTH; i++) begin
            if (i == 0) begin
                queue_write(i, 16'h8000);
            end else if (i == STORE_DEPTH - 1) begin
                queue_write(i, 16'h7FFF);
            end else begin
                queue_write(i, blcs_pkg::WVAL_W'($urandom));
            end
        end
        wait_idle();

        // Directed part with zero bias. A black one-pixel image scores
        // exactly zero, which must predict non-zero.
        write_bias('0);
        queue_pixel(0, 1'b1, 0);
        queue_write(0, 16'h7FFF);
        queue_pixel(255, 1'b1, 0);
        queue_pixel(255, 1'b1, 255);
        queue_write(0, 16'h8000);
        queue_pixel(255, 1'b1, 1);
        // Reserved opcode, even with tlast set, is ignored.
        queue_word(OPC_RESERVED, 1'b1, '1, '1, '1, '0);
        // A clear and a weight write in the middle of an image.
        queue_pixel(17, 1'b0, 5);
        queue_word(blcs_pkg::OP_CLEAR, 1'b1, '1, '1, '1, '1);
        queue_write(1, 16'h0100);
        queue_pixel(200, 1'b1, 0);
        queue_word(blcs_pkg::OP_CLEAR, 1'b0, '0, '0, '0, '0);
        queue_pixel(255, 1'b1, 128);
        wait_idle();

        // Largest bias against the most negative product.
        write_bias(32'h7FFF_FFFF);
        queue_pixel(255, 1'b1, 0);
        queue_pixel(0, 1'b1, 9);
        wait_idle();

        // Most negative bias against the largest product.
        write_bias(32'h8000_0000);
        queue_write(0, 16'h7FFF);
        queue_pixel(255, 1'b1, 0);
        queue_pixel(255, 1'b1, 64);
        wait_idle();

        // One image longer than the store: the pixels past its end add nothing.
        write_bias(bias_draw());
        for (int k = 0; k < STORE_DEPTH + 6; k++) begin
            queue_pixel($urandom_range(0, 255), k == STORE_DEPTH + 5, label_draw());
        end
        queue_pixel($urandom_range(0, 255), 1'b1, label_draw());
        wait_idle();

        // Random phases, each with its own bias; the long receiver hold-off
        // is started early in the second one.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_bias(bias_draw());
            queue_random_phase(PHASE_WORDS);
            if (p == 1) begin
                hold_go = 1'b1;
            end
            wait_idle();
        end

        if (expected_scores.size() > 0) begin
            $display("score check: %0d results never arrived", expected_scores.size());
            mismatches += expected_scores.size();
        end
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
